// ----- rtl/tcgb_pkg.sv -----
// ----------------------------------------------------------------------------
// tcgb_pkg
// Shared types and constants for the text cursor glyph blitter.
// ----------------------------------------------------------------------------
package tcgb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_BASE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_BASE_Y  = 3'd4;

    localparam logic [BYTE_W-1:0] WRAP_WIDTH_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] GLYPH_STEP       = 8'd8;
    localparam logic [BYTE_W-1:0] NIBBLE_MASK      = 8'h0F;
    localparam logic [BYTE_W-1:0] ROW_MASK         = 8'h70;

    // character codes with special meaning
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;

    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] wrap_width;
        logic [BYTE_W-1:0] line_start;
        logic [BYTE_W-1:0] color_offset;
        logic [BYTE_W-1:0] font_base_x;
        logic [BYTE_W-1:0] font_base_y;
    } t_cfg;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] new_x;
        logic [BYTE_W-1:0] new_y;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] dest_x;
        logic [BYTE_W-1:0] dest_y;
        logic [BYTE_W-1:0] src_x;
        logic [BYTE_W-1:0] src_y;
    } t_blit;

endpackage

// ----- rtl/tcgb_cursor.sv -----
// ----------------------------------------------------------------------------
// tcgb_cursor
// Next-cursor and blit request logic for one item, purely combinational.
// ----------------------------------------------------------------------------
module tcgb_cursor
    import tcgb_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_item             i_item,
    input  logic [BYTE_W-1:0] i_cur_x,
    input  logic [BYTE_W-1:0] i_cur_y,
    output logic [BYTE_W-1:0] o_next_x,
    output logic [BYTE_W-1:0] o_next_y,
    output logic              o_emit,
    output t_blit             o_blit
);

    logic [BYTE_W:0]   wrap_limit;
    logic              wrap;
    logic [BYTE_W-1:0] glyph;
    logic [BYTE_W-1:0] draw_x;
    logic [BYTE_W-1:0] draw_y;

    assign wrap_limit = {1'b0, i_cfg.wrap_width} + {1'b0, i_cfg.line_start};
    assign wrap       = {1'b0, i_cur_x} >= wrap_limit;
    assign glyph      = i_item.char_code + i_cfg.color_offset;
    assign draw_x     = wrap ? (i_cur_x - i_cfg.wrap_width) : i_cur_x;
    assign draw_y     = wrap ? (i_cur_y + GLYPH_STEP) : i_cur_y;

    assign o_blit.dest_x = draw_x;
    assign o_blit.dest_y = draw_y;
    assign o_blit.src_x  = {1'b0, (glyph[BYTE_W-5:0] & NIBBLE_MASK[BYTE_W-5:0]), 3'b000}
                           | i_cfg.font_base_x;
    assign o_blit.src_y  = (glyph & ROW_MASK) | i_cfg.font_base_y;

    always_comb begin
        o_next_x = i_cur_x;
        o_next_y = i_cur_y;
        o_emit   = 1'b0;
        if (i_item.command == CMD_SET) begin
            o_next_x = i_item.new_x;
            o_next_y = i_item.new_y;
        end else begin
            unique case (i_item.char_code)
                CHAR_NUL: begin
                end
                CHAR_SPACE: begin
                    o_next_x = i_cur_x + GLYPH_STEP;
                end
                CHAR_LF: begin
                    o_next_y = i_cur_y + GLYPH_STEP;
                end
                CHAR_CR: begin
                    o_next_x = i_cfg.line_start;
                end
                default: begin
                    o_next_x = draw_x + GLYPH_STEP;
                    o_next_y = draw_y;
                    o_emit   = 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- rtl/text_cursor_glyph_blit_top.sv -----
// ----------------------------------------------------------------------------
// text_cursor_glyph_blit_top
// Text cursor with glyph blit request generation from character beats.
// ----------------------------------------------------------------------------
// Path: input beat to blit request through the input register, then the
//   result register; items that draw nothing update the cursor only.
// Throughput: 1 beat per cycle unless stalled; one cursor update stage.
// Reset: synchronous, active low; cursor to (0,0), wrap width to 128,
//   other config registers to 0, both pipeline stages empty.
module text_cursor_glyph_blit_top
    import tcgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [BYTE_W-1:0]    i_char_code,
    input  logic [BYTE_W-1:0]    i_new_x,
    input  logic [BYTE_W-1:0]    i_new_y,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_dest_x,
    output logic [BYTE_W-1:0]    o_dest_y,
    output logic [BYTE_W-1:0]    o_src_x,
    output logic [BYTE_W-1:0]    o_src_y
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_item             r_in;
    logic [BYTE_W-1:0] r_cur_x;
    logic [BYTE_W-1:0] r_cur_y;
    logic              r_out_valid;
    t_blit             r_out;

    logic [BYTE_W-1:0] n_cur_x;
    logic [BYTE_W-1:0] n_cur_y;
    logic              emit;
    t_blit             blit;
    logic              out_free;
    logic              fire;
    logic              in_take;

    // Configuration registers: must be written only while idle, so no hazard with
    // the item in flight; the user must ensure this, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_width   <= WRAP_WIDTH_RESET;
            r_cfg.line_start   <= '0;
            r_cfg.color_offset <= '0;
            r_cfg.font_base_x  <= '0;
            r_cfg.font_base_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WRAP_WIDTH:   r_cfg.wrap_width   <= i_cfg_data;
                REG_LINE_START:   r_cfg.line_start   <= i_cfg_data;
                REG_COLOR_OFFSET: r_cfg.color_offset <= i_cfg_data;
                REG_FONT_BASE_X:  r_cfg.font_base_x  <= i_cfg_data;
                REG_FONT_BASE_Y:  r_cfg.font_base_y  <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // The result register is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // Retire the held item unless it draws a glyph and has nowhere to go.
    assign fire     = r_in_valid && (!emit || out_free);
    // Hold off new beats only while the held item cannot retire.
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command   <= i_command;
            r_in.char_code <= i_char_code;
            r_in.new_x     <= i_new_x;
            r_in.new_y     <= i_new_y;
        end
    end

    tcgb_cursor u_cursor (
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .i_cur_x  (r_cur_x),
        .i_cur_y  (r_cur_y),
        .o_next_x (n_cur_x),
        .o_next_y (n_cur_y),
        .o_emit   (emit),
        .o_blit   (blit)
    );

    // Cursor state: advance once per retired item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else if (fire) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

    // Result register: load a new blit beat, or drop the old one once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= blit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dest_x    = r_out.dest_x;
    assign o_dest_y    = r_out.dest_y;
    assign o_src_x     = r_out.src_x;
    assign o_src_y     = r_out.src_y;

    // A new blit beat appears only from a retired drawing item.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(fire && emit))
        else $error("blit beat without a drawing item");

    // A stall on input only while an item is held.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input stage");

    // A set command loads the cursor and draws nothing.
    a_set_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.command == CMD_SET) |=>
            (r_cur_x == $past(r_in.new_x) && r_cur_y == $past(r_in.new_y)))
        else $error("set command did not load the cursor");

    a_set_no_blit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.command == CMD_SET) |-> !emit)
        else $error("set command produced a blit");

endmodule
